// File: design/rpp_pkg.sv
// rpp_pkg: shared types, constants and saturation helpers for the rotator position pid
// used by rpp_mul, rpp_isqrt and rotator_position_pid; no dependencies
package rpp_pkg;

  localparam int FRAC = 16;
  localparam int ARRIVAL_WINDOW_DEF = 65536;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int ROOT_IN_W = 56;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_PERIOD = 3'd3,
    CFG_BIAS   = 3'd4,
    CFG_ACCEL  = 3'd5,
    CFG_SPEED  = 3'd6,
    CFG_SETTLE = 3'd7
  } cfg_idx_t;

  localparam logic [23:0] KP_RST     = 24'd5242880;
  localparam logic [23:0] KI_RST     = 24'd26214;
  localparam logic [23:0] KD_RST     = 24'd131072;
  localparam logic [16:0] PERIOD_RST = 17'd655;
  localparam logic [16:0] BIAS_RST   = 17'd0;
  localparam logic [22:0] ACCEL_RST  = 23'd589824;
  localparam logic [23:0] SPEED_RST  = 24'd8388608;
  localparam logic [23:0] SETTLE_RST = 24'd98304;

  // clamp a 36-bit signed value into 32 bits
  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    if (x > 36'sd2147483647) return 32'sh7fffffff;
    if (x < -36'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // magnitude of a 32-bit signed value
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // sign and magnitude to saturated 32-bit signed
  function automatic logic signed [31:0] ssat(input logic neg, input logic [47:0] m);
    if (neg) begin
      if (m >= 48'h80000000) return 32'sh80000000;
      return ~m[31:0] + 32'd1;
    end
    if (m > 48'h7fffffff) return 32'sh7fffffff;
    return m[31:0];
  endfunction

  // raw product scaled down with rounding, then signed saturation
  function automatic logic signed [31:0] mulq(input logic neg, input logic [55:0] p);
    logic [56:0] r;
    r = {1'b0, p} + (57'd1 << (FRAC - 1));
    return ssat(neg, {7'd0, r[FRAC +: 41]});
  endfunction

endpackage

// File: design/rpp_mul.sv
// rpp_mul: shift-add multiplier, one multiplier bit per cycle
// depends on rpp_pkg
module rpp_mul import rpp_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CW = (B_W > 1) ? $clog2(B_W) : 1;

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [A_W-1:0] a_r;
  logic [A_W-1:0] hi;
  logic [B_W-1:0] lo;
  logic [A_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi <= sum[A_W:1];
        lo <= {sum[0], lo[B_W-1:1]};
        if (cnt == CW'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// File: design/rpp_isqrt.sv
// rpp_isqrt: digit-by-digit integer square root, one root bit per cycle
// depends on rpp_pkg
module rpp_isqrt import rpp_pkg::*; #(
  parameter int IN_W = ROOT_IN_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   v,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;
  localparam int CW = $clog2(RW);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [IN_W-1:0] vs;
  logic [RW+1:0]   rem;
  logic [RW+3:0]   rs;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            ge;

  assign rs    = {rem, vs[IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rs >= trial;
  assign diff  = rs - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        vs   <= v;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        vs   <= {vs[IN_W-3:0], 2'b00};
        rem  <= ge ? diff[RW+1:0] : rs[RW+1:0];
        root <= {root[RW-2:0], ge};
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// File: design/rotator_position_pid.sv
// rotator_position_pid: top level of the rotator position controller
// depends on rpp_pkg, rpp_mul and rpp_isqrt
//
// Position controller for an antenna rotator. A start item latches target and
// present drive speed, clears the integral and enables the loop; a stop item
// halts the motor and disables it. A sample item, with the loop enabled, checks
// arrival, and on a period tick runs the speed bound, PID, acceleration limit
// and speed clamp, all in Q15.16 with saturation. One item is worked on at a
// time. A control-tick sample makes six passes through the shared shift-add
// multiplier (one multiplier bit per cycle), and uses the square root unit
// (one root bit per cycle) and the restoring divider for the derivative (one
// quotient bit per cycle). The result sits in an output register; the next item
// is taken once it has been written there, so a stalled receiver adds its stall
// to the item time. Configuration is written through cfg_write/cfg_index/cfg_data.
module rotator_position_pid import rpp_pkg::*; #(
  parameter int ARRIVAL_WINDOW = ARRIVAL_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic               period_tick,
  input  logic signed [31:0] position,
  input  logic signed [31:0] encoder_speed,
  input  logic signed [31:0] target_position,
  input  logic signed [31:0] present_drive,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive_speed,
  output logic               drive_update,
  output logic               motor_halt,
  output logic               loop_enabled,
  output logic               move_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ROOTMUL, S_ROOT, S_INTMUL, S_DIV, S_DER,
    S_PMUL, S_IMUL, S_DMUL, S_LIMMUL, S_LIMIT, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [23:0] gain_proportional, gain_integral, gain_derivative;
  logic [16:0] loop_period, output_bias;
  logic [22:0] accel_limit;
  logic [23:0] speed_limit, settle_speed;

  // latched item
  op_t                op_q;
  logic               tick_q;
  logic signed [31:0] pos_q, enc_q, tgt_q, drv_q;

  // controller state
  logic               enabled_flag, aiming_flag;
  logic signed [31:0] held_target, commanded_speed, integral_sum, previous_error;

  // working registers
  logic signed [31:0] err, serr, der, o_q;
  logic signed [35:0] acc;
  logic [39:0]        lim;
  logic               dd_neg;
  logic [47:0]        div_n;
  logic [16:0]        div_r;
  logic [5:0]         div_cnt;

  // result being built
  logic signed [31:0] res_speed;
  logic               res_update, res_halt, res_done;

  // shared units
  logic        mul_start, mul_done;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic        sq_start, sq_done;
  logic [27:0] root;

  rpp_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  rpp_isqrt #(.IN_W(ROOT_IN_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .v(mul_p),
    .done(sq_done), .root(root)
  );

  assign in_ready = (state == S_IDLE);

  // a zero period counts as one lsb
  logic [16:0] per_eff;
  assign per_eff = (loop_period == 17'd0) ? 17'd1 : loop_period;

  // position error against the held target and arrival test
  logic signed [31:0] err_c;
  logic [31:0]        ae_c, enc_mag;
  logic               arrive;
  assign err_c   = sat36({{4{held_target[31]}}, held_target} - {{4{pos_q[31]}}, pos_q});
  assign ae_c    = mag32(err_c);
  assign enc_mag = mag32(enc_q);
  assign arrive  = (ae_c < 32'(ARRIVAL_WINDOW)) && (enc_mag <= {8'd0, settle_speed});

  // speed error from the signed bound
  logic signed [31:0] bound, serr_c;
  assign bound  = err[31] ? -$signed({4'd0, root}) : $signed({4'd0, root});
  assign serr_c = sat36({{4{bound[31]}}, bound} - {{4{commanded_speed[31]}}, commanded_speed});

  // integral update and derivative numerator
  logic signed [31:0] mq, integ_c, dd_c;
  assign mq      = mulq(serr[31], mul_p);
  assign integ_c = sat36({{4{integral_sum[31]}}, integral_sum} + {{4{mq[31]}}, mq});
  assign dd_c    = sat36({{4{serr[31]}}, serr} - {{4{previous_error[31]}}, previous_error});

  // product of the current multiply, with the sign of its value operand
  logic               mq_neg;
  logic signed [31:0] mq_sel;
  always_comb begin
    case (state)
      S_IMUL:  mq_neg = integral_sum[31];
      S_DMUL:  mq_neg = der[31];
      default: mq_neg = serr[31];
    endcase
  end
  assign mq_sel = mulq(mq_neg, mul_p);

  logic signed [35:0] acc_sum;
  assign acc_sum = acc + {{4{mq_sel[31]}}, mq_sel} + {19'd0, output_bias};

  // divider step
  logic [17:0] div_rs;
  logic        div_ge;
  assign div_rs = {div_r, div_n[47]};
  assign div_ge = div_rs >= {1'b0, per_eff};
  logic [17:0] div_diff;
  assign div_diff = div_rs - {1'b0, per_eff};

  // acceleration limit and speed clamp
  logic signed [35:0] delta, o_lim36;
  logic [35:0]        dmag;
  logic [24:0]        step;
  logic signed [31:0] o_lim, o_fin;
  logic [31:0]        olim_mag;
  always_comb begin
    delta = {{4{o_q[31]}}, o_q} - {{4{commanded_speed[31]}}, commanded_speed};
    dmag  = delta[35] ? (~delta + 36'd1) : delta;
    step  = 25'((lim + (40'd1 << (FRAC - 1))) >> FRAC);
    if (dmag > {12'd0, lim[39:FRAC]}) begin
      o_lim36 = delta[35]
              ? {{4{commanded_speed[31]}}, commanded_speed} - {11'd0, step}
              : {{4{commanded_speed[31]}}, commanded_speed} + {11'd0, step};
    end else begin
      o_lim36 = {{4{o_q[31]}}, o_q};
    end
    o_lim    = sat36(o_lim36);
    olim_mag = mag32(o_lim);
    if (olim_mag > {8'd0, speed_limit}) begin
      o_fin = o_lim[31] ? -$signed({8'd0, speed_limit}) : $signed({8'd0, speed_limit});
    end else begin
      o_fin = o_lim;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= KP_RST;
      gain_integral     <= KI_RST;
      gain_derivative   <= KD_RST;
      loop_period       <= PERIOD_RST;
      output_bias       <= BIAS_RST;
      accel_limit       <= ACCEL_RST;
      speed_limit       <= SPEED_RST;
      settle_speed      <= SETTLE_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP:     gain_proportional <= cfg_data;
        CFG_KI:     gain_integral     <= cfg_data;
        CFG_KD:     gain_derivative   <= cfg_data;
        CFG_PERIOD: loop_period       <= cfg_data[16:0];
        CFG_BIAS:   output_bias       <= cfg_data[16:0];
        CFG_ACCEL:  accel_limit       <= cfg_data[22:0];
        CFG_SPEED:  speed_limit       <= cfg_data;
        CFG_SETTLE: settle_speed      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      mul_start       <= 1'b0;
      sq_start        <= 1'b0;
      enabled_flag    <= 1'b0;
      aiming_flag     <= 1'b0;
      held_target     <= '0;
      commanded_speed <= '0;
      integral_sum    <= '0;
      previous_error  <= '0;
    end else begin
      mul_start <= 1'b0;
      sq_start  <= 1'b0;
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= op_t'(operation);
            tick_q <= period_tick;
            pos_q  <= position;
            enc_q  <= encoder_speed;
            tgt_q  <= target_position;
            drv_q  <= present_drive;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_speed  <= '0;
          res_update <= 1'b0;
          res_halt   <= 1'b0;
          res_done   <= 1'b0;
          state      <= S_FIN;
          case (op_q)
            OP_START: begin
              held_target     <= tgt_q;
              commanded_speed <= drv_q;
              integral_sum    <= '0;
              previous_error  <= '0;
              aiming_flag     <= 1'b1;
              enabled_flag    <= 1'b1;
            end
            OP_STOP: begin
              aiming_flag     <= 1'b0;
              commanded_speed <= drv_q;
              enabled_flag    <= 1'b0;
              res_halt        <= 1'b1;
            end
            OP_SAMPLE: begin
              if (enabled_flag) begin
                if (arrive) begin
                  res_halt     <= 1'b1;
                  integral_sum <= '0;
                  if (aiming_flag) begin
                    res_done     <= 1'b1;
                    aiming_flag  <= 1'b0;
                    enabled_flag <= 1'b0;
                  end
                end else if (tick_q) begin
                  // bound squared: 2 * accel * |e|
                  err       <= err_c;
                  mul_a     <= ae_c;
                  mul_b     <= {accel_limit, 1'b0};
                  mul_start <= 1'b1;
                  state     <= S_ROOTMUL;
                end
              end
            end
            default: ;
          endcase
        end
        S_ROOTMUL: begin
          if (mul_done) begin
            sq_start <= 1'b1;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            serr      <= serr_c;
            mul_a     <= mag32(serr_c);
            mul_b     <= {7'd0, per_eff};
            mul_start <= 1'b1;
            state     <= S_INTMUL;
          end
        end
        S_INTMUL: begin
          if (mul_done) begin
            integral_sum <= integ_c;
            dd_neg       <= dd_c[31];
            // rounded quotient: (|d| << frac + per/2) / per
            div_n        <= {mag32(dd_c), 16'd0} + {32'd0, per_eff[16:1]};
            div_r        <= '0;
            div_cnt      <= '0;
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          div_r   <= div_ge ? div_diff[16:0] : div_rs[16:0];
          div_n   <= {div_n[46:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd47) begin
            state <= S_DER;
          end
        end
        S_DER: begin
          der       <= ssat(dd_neg, div_n);
          mul_a     <= mag32(serr);
          mul_b     <= gain_proportional;
          mul_start <= 1'b1;
          state     <= S_PMUL;
        end
        S_PMUL: begin
          if (mul_done) begin
            acc       <= {{4{mq_sel[31]}}, mq_sel};
            mul_a     <= mag32(integral_sum);
            mul_b     <= gain_integral;
            mul_start <= 1'b1;
            state     <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            acc       <= acc + {{4{mq_sel[31]}}, mq_sel};
            mul_a     <= mag32(der);
            mul_b     <= gain_derivative;
            mul_start <= 1'b1;
            state     <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            o_q            <= sat36(acc_sum);
            previous_error <= serr;
            // acceleration step: accel * period
            mul_a          <= {15'd0, per_eff};
            mul_b          <= {1'b0, accel_limit};
            mul_start      <= 1'b1;
            state          <= S_LIMMUL;
          end
        end
        S_LIMMUL: begin
          if (mul_done) begin
            lim   <= mul_p[39:0];
            state <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          aiming_flag     <= 1'b1;
          commanded_speed <= o_fin;
          res_speed       <= o_fin;
          res_update      <= 1'b1;
          state           <= S_FIN;
        end
        S_FIN: begin
          // hand the item to the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            drive_speed  <= res_speed;
            drive_update <= res_update;
            motor_halt   <= res_halt;
            move_done    <= res_done;
            loop_enabled <= enabled_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // units are only ever busy while an item is in progress
  a_idle_no_mul: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mul_done && !sq_done)
    else $error("arithmetic unit finished while idle");

  // a completed move always halts and leaves the loop disabled
  a_done_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> motor_halt && !loop_enabled && !drive_update)
    else $error("move_done without halt");

  // an update never comes with a halt
  a_update_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_update |-> !motor_halt && loop_enabled)
    else $error("drive update together with halt");

  // a new result only appears from the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the final state");

endmodule

// File: sim/rotator_position_pid_tb.sv
// rotator_position_pid_tb: self-checking bench for the rotator position controller
// depends on rpp_pkg and rotator_position_pid; drives items through valid/ready
// and compares every result against a behavioural copy of the control law
module rotator_position_pid_tb;
  import rpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint WINDOW = 65536;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    op_t              op;
    logic             tick;
    logic signed [31:0] pos;
    logic signed [31:0] enc;
    logic signed [31:0] tgt;
    logic signed [31:0] drv;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic             upd;
    logic             halt;
    logic             en;
    logic             done;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic period_tick = 1'b0;
  logic signed [31:0] position = '0, encoder_speed = '0;
  logic signed [31:0] target_position = '0, present_drive = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] drive_speed;
  logic drive_update, motor_halt, loop_enabled, move_done;

  rotator_position_pid i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // controller copy: registers and loop state
  longint unsigned gains [8];
  bit     run_on, aiming;
  longint tgt_q, cmd_speed, integ, prev_err;

  cmd_t   pending_items [$];
  resp_t  expected_results [$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  int     hold_off = 0;
  bit     hold_req = 1'b0;
  bit     hold_used = 1'b0;

  function automatic longint clamp(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint signed_clamp(bit neg, longint unsigned m);
    if (m > longint'(VMAX) + 1) m = longint'(VMAX) + 1;
    return clamp(neg ? -longint'(m) : longint'(m));
  endfunction

  // value times unsigned gain, rounded half away from zero
  function automatic longint scale_mul(longint a, longint unsigned g);
    longint unsigned m, hi, lo, r;
    m = absval(a);
    hi = (m >> 32) * g;
    lo = (m & 64'hFFFFFFFF) * g;
    if (hi >= (64'd1 << 46)) return signed_clamp(a < 0, 64'd1 << 62);
    r = (hi << 16) + ((lo + 64'd32768) >> 16);
    return signed_clamp(a < 0, r);
  endfunction

  // value over period, rounded to nearest
  function automatic longint scale_div(longint a, longint unsigned p);
    longint unsigned m, q, rm, r;
    m = absval(a);
    q = m / p;
    rm = m % p;
    if (q >= (64'd1 << 46)) return signed_clamp(a < 0, 64'd1 << 62);
    r = (q << 16) + (((rm << 16) + p / 2) / p);
    return signed_clamp(a < 0, r);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void reset_model();
    gains[CFG_KP] = KP_RST;     gains[CFG_KI] = KI_RST;
    gains[CFG_KD] = KD_RST;     gains[CFG_PERIOD] = PERIOD_RST;
    gains[CFG_BIAS] = BIAS_RST; gains[CFG_ACCEL] = ACCEL_RST;
    gains[CFG_SPEED] = SPEED_RST; gains[CFG_SETTLE] = SETTLE_RST;
    run_on = 0; aiming = 0;
    tgt_q = 0; cmd_speed = 0; integ = 0; prev_err = 0;
  endfunction

  function automatic resp_t control_step(cmd_t c);
    resp_t r;
    longint e, bound, serr, der, o, delta, stp;
    longint unsigned ae, per, root, lim;
    r = '0;
    if (c.op == OP_START) begin
      tgt_q = c.tgt; cmd_speed = c.drv;
      integ = 0; prev_err = 0;
      aiming = 1; run_on = 1;
    end else if (c.op == OP_STOP) begin
      aiming = 0; cmd_speed = c.drv; run_on = 0;
      r.halt = 1;
    end else if (c.op == OP_SAMPLE && run_on) begin
      e = clamp(tgt_q - longint'(c.pos));
      ae = absval(e);
      if (ae < WINDOW && absval(longint'(c.enc)) <= gains[CFG_SETTLE]) begin
        r.halt = 1;
        if (aiming) begin
          r.done = 1; aiming = 0; run_on = 0;
        end
        integ = 0;
      end else if (c.tick) begin
        per = gains[CFG_PERIOD] != 0 ? gains[CFG_PERIOD] : 1;
        root = int_root(2 * gains[CFG_ACCEL] * ae);
        bound = clamp(e < 0 ? -longint'(root) : longint'(root));
        serr = clamp(bound - cmd_speed);
        integ = clamp(integ + scale_mul(serr, per));
        der = scale_div(clamp(serr - prev_err), per);
        o = clamp(scale_mul(serr, gains[CFG_KP]) + scale_mul(integ, gains[CFG_KI])
                  + scale_mul(der, gains[CFG_KD]) + longint'(gains[CFG_BIAS]));
        prev_err = serr;
        delta = o - cmd_speed;
        lim = gains[CFG_ACCEL] * per;
        if (absval(delta) > (lim >> 16)) begin
          stp = longint'((lim + 64'd32768) >> 16);
          o = clamp(delta < 0 ? cmd_speed - stp : cmd_speed + stp);
        end
        if (absval(o) > gains[CFG_SPEED])
          o = o < 0 ? -longint'(gains[CFG_SPEED]) : longint'(gains[CFG_SPEED]);
        aiming = 1;
        cmd_speed = o;
        r.speed = o[31:0];
        r.upd = 1;
      end
    end
    r.en = run_on;
    return r;
  endfunction

  // driver: bursts and gaps, items predicted on acceptance
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(control_step(
        cmd_t'{op_t'(operation), period_tick, position, encoder_speed,
               target_position, present_drive}));
      void'(pending_items.pop_front());
    end
  end

  // remembers whether the item on the port went through at the last rising edge
  logic in_ready_q = 1'b0;
  always @(posedge clk) in_ready_q <= in_ready & in_valid;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || (in_valid && in_ready_q)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        operation <= pending_items[0].op;
        period_tick <= pending_items[0].tick;
        position <= pending_items[0].pos;
        encoder_speed <= pending_items[0].enc;
        target_position <= pending_items[0].tgt;
        present_drive <= pending_items[0].drv;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_off <= 3000;
      hold_used <= 1'b1;
      out_ready <= 1'b0;
    end else if (stall_phase[9]) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result speed=%0d upd=%0b halt=%0b en=%0b done=%0b",
                 $time, drive_speed, drive_update, motor_halt, loop_enabled, move_done);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (want != {drive_speed, drive_update, motor_halt, loop_enabled, move_done}) begin
          $display("%0t: mismatch expected speed=%0d upd=%0b halt=%0b en=%0b done=%0b",
                   $time, want.speed, want.upd, want.halt, want.en, want.done);
          $display("%0t:          actual   speed=%0d upd=%0b halt=%0b en=%0b done=%0b",
                   $time, drive_speed, drive_update, motor_halt, loop_enabled, move_done);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 200000)) - 100000;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t make_item(op_t op, bit tick, int p, int e, int t, int d);
    return cmd_t'{op, tick, p, e, t, d};
  endfunction

  // a move: start, ticks converging, sometimes arrival, rare stop, invalid ops and random samples
  task automatic queue_move(int n);
    int t, p, sp;
    t = ($urandom_range(0, 3) == 0) ? rand_word() : $signed($urandom_range(0, 4000000)) - 2000000;
    p = t + $signed($urandom_range(0, 2000000)) - 1000000;
    pending_items.push_back(make_item(OP_START, 0, 0, 0, t, rand_word()));
    for (int k = 0; k < n; k++) begin
      sp = $signed($urandom_range(0, 200000)) - 100000;
      p = p + (t - p) / 3;
      case ($urandom_range(0, 9))
        0: pending_items.push_back(make_item(OP_STOP, 1'($urandom()), rand_word(), rand_word(),
                                             rand_word(), rand_word()));
        1: pending_items.push_back(make_item(OP_SAMPLE, 1'($urandom()), t, 0, rand_word(), 0));
        2: pending_items.push_back(make_item(op_t'(2'd3), 1'($urandom()), rand_word(),
                                             rand_word(), rand_word(), rand_word()));
        3: pending_items.push_back(make_item(OP_SAMPLE, 1'($urandom()), rand_word(),
                                             rand_word(), rand_word(), rand_word()));
        default: pending_items.push_back(make_item(OP_SAMPLE, $urandom_range(0, 3) != 0, p,
                                                   sp, rand_word(), rand_word()));
      endcase
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    gains[idx] = (idx == CFG_PERIOD || idx == CFG_BIAS) ? val[16:0] :
                 (idx == CFG_ACCEL) ? val[22:0] : val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // idle point: everything out, then a pause for a control pass in flight
  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    pending_items.push_back(make_item(OP_SAMPLE, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_START, 0, 0, 0, 32'sh7fffffff, 32'sh80000000));
    pending_items.push_back(make_item(OP_SAMPLE, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 32'sh80000000, 32'sh7fffffff, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 32'sh7fffffff, 0, 0, 0));
    pending_items.push_back(make_item(op_t'(2'd3), 1, 32'sh7fffffff, 32'sh80000000,
                                      32'sh7fffffff, 32'sh80000000));
    pending_items.push_back(make_item(OP_STOP, 1, 0, 0, 0, 32'sh7fffffff));
    pending_items.push_back(make_item(OP_START, 0, 0, 0, 32'sh80000000, 32'sh7fffffff));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 32'sh7fffffff, 32'sh80000000, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 32'sh80000000, 1, 0, 0));
    pending_items.push_back(make_item(OP_START, 0, 0, 0, 100000, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 0, 100000, 0, 0, 0));
    pending_items.push_back(make_item(OP_START, 0, 0, 0, 100000, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 100000 - 65535, -98304, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 100000, 98304, 0, 0));
    pending_items.push_back(make_item(OP_SAMPLE, 1, 100000, 98305, 0, 0));
    drain();

    // random phases across settings, extremes first
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_KP, 24'hffffff); write_reg(CFG_KI, 24'hffffff);
        write_reg(CFG_KD, 24'hffffff); write_reg(CFG_PERIOD, 24'd65536);
        write_reg(CFG_BIAS, 24'd65536); write_reg(CFG_ACCEL, 24'd4718592);
        write_reg(CFG_SPEED, 24'd8388608); write_reg(CFG_SETTLE, 24'd8388608);
      end else if (ph == 1) begin
        write_reg(CFG_KP, 24'd0); write_reg(CFG_KI, 24'd0); write_reg(CFG_KD, 24'd0);
        write_reg(CFG_PERIOD, 24'd0); write_reg(CFG_BIAS, 24'd0); write_reg(CFG_ACCEL, 24'd0);
        write_reg(CFG_SPEED, 24'd0); write_reg(CFG_SETTLE, 24'd0);
      end else if (ph == 2) begin
        write_reg(CFG_PERIOD, 24'h01ffff); write_reg(CFG_BIAS, 24'h01ffff);
        write_reg(CFG_ACCEL, 24'h7fffff); write_reg(CFG_SPEED, 24'hffffff);
        write_reg(CFG_SETTLE, 24'hffffff); write_reg(CFG_KP, 24'h800000);
      end else begin
        write_reg(CFG_KP, 24'($urandom_range(0, 24'h200000)));
        write_reg(CFG_KI, 24'($urandom_range(0, 24'h40000)));
        write_reg(CFG_KD, 24'($urandom_range(0, 24'h40000)));
        write_reg(CFG_PERIOD, 24'($urandom_range(655, 65536)));
        write_reg(CFG_BIAS, 24'($urandom_range(0, 65536)));
        write_reg(CFG_ACCEL, 24'($urandom_range(0, 4718592)));
        write_reg(CFG_SPEED, 24'($urandom_range(0, 8388608)));
        write_reg(CFG_SETTLE, 24'($urandom_range(0, 300000)));
      end
      for (int mv = 0; mv < 8; mv++) queue_move($urandom_range(4, 25));
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) hold_req = 1'b1;
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
